// ----- sv/mvd_pkg.sv -----
package mvd_pkg;

  localparam int THR_W      = 17;
  localparam int HOLE_W     = 16;
  localparam int HALF_W     = 15;
  localparam int PCT_W      = 7;
  localparam int DEB_W      = 8;
  localparam int DIST_W     = 16;
  localparam int CHAN_W     = 3;
  localparam int RAD_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int PROD_W      = 24;
  localparam int QIN_W       = 22;
  localparam int MUL_W       = 45;
  localparam int RECIP_SHIFT = 27;
  localparam logic [22:0] RECIP_25 = 23'd5368710;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 17'd500;
  localparam logic [HOLE_W-1:0] HOLE_RST      = 16'd300;
  localparam logic [PCT_W-1:0]  HYST_RST      = 7'd10;
  localparam logic [DEB_W-1:0]  DEB_ENTER_RST = 8'd3;
  localparam logic [DEB_W-1:0]  DEB_EXIT_RST  = 8'd5;
  localparam logic [PCT_W-1:0]  PCT_MAX       = 7'd100;
  localparam logic [DEB_W-1:0]  COUNT_MAX     = 8'd255;

  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_HOLE      = 3'd1,
    REG_HYST      = 3'd2,
    REG_DEB_ENTER = 3'd3,
    REG_DEB_EXIT  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [THR_W-1:0]  exit_level;
    logic [HALF_W-1:0] half_hole;
    logic [DEB_W-1:0]  deb_enter;
    logic [DEB_W-1:0]  deb_exit;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              in_range;
    logic              above;
    logic              below;
    logic              eof;
  } entry_t;

endpackage

// ----- sv/mvd_cfg.sv -----
module mvd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvd_pkg::CFG_DATA_W-1:0] cfg_data,
  output mvd_pkg::cfg_t                  cfg,
  output logic                           busy
);
  import mvd_pkg::*;

  logic [THR_W-1:0]  threshold;
  logic [HOLE_W-1:0] hole;
  logic [PCT_W-1:0]  pct;
  logic [DEB_W-1:0]  deb_enter;
  logic [DEB_W-1:0]  deb_exit;
  logic [PROD_W-1:0] prod;
  logic [MUL_W-1:0]  mul;
  logic [THR_W-1:0]  exit_level;
  logic [1:0]        settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RST;
      hole      <= HOLE_RST;
      pct       <= HYST_RST;
      deb_enter <= DEB_ENTER_RST;
      deb_exit  <= DEB_EXIT_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_THRESHOLD: threshold <= cfg_data[THR_W-1:0];
        REG_HOLE:      hole <= cfg_data[HOLE_W-1:0];
        REG_HYST:      pct <= (cfg_data[PCT_W-1:0] > PCT_MAX) ? PCT_MAX : cfg_data[PCT_W-1:0];
        REG_DEB_ENTER: deb_enter <= cfg_data[DEB_W-1:0];
        REG_DEB_EXIT:  deb_exit <= cfg_data[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // The exit level is threshold minus floor(threshold * pct / 100), the latter
  // computed as a quarter of the product times a reciprocal of 25.
  always_ff @(posedge clk) begin
    prod       <= PROD_W'(threshold) * PROD_W'(pct);
    mul        <= MUL_W'(prod[PROD_W-1:2]) * MUL_W'(RECIP_25);
    exit_level <= threshold - mul[RECIP_SHIFT+THR_W-1:RECIP_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      settle <= SETTLE_CYCLES;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign busy           = (settle != 2'd0);
  assign cfg.threshold  = threshold;
  assign cfg.exit_level = exit_level;
  assign cfg.half_hole  = hole[HOLE_W-1:1];
  assign cfg.deb_enter  = deb_enter;
  assign cfg.deb_exit   = deb_exit;

endmodule

// ----- sv/mvd_front.sv -----
module mvd_front #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mvd_pkg::CHAN_W-1:0] channel,
  input  logic                       target_valid,
  input  logic [mvd_pkg::DIST_W-1:0] measured_distance_mm,
  input  logic                       end_of_frame,
  input  mvd_pkg::cfg_t              cfg,
  input  logic                       busy,
  output logic                       q_valid,
  output mvd_pkg::entry_t            q_entry,
  input  logic                       q_pop
);
  import mvd_pkg::*;

  entry_t             mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [RAD_W-1:0]   radius;
  entry_t             entry;
  logic               push;

  always_comb begin
    radius         = target_valid ? (RAD_W'(cfg.half_hole) + RAD_W'(measured_distance_mm))
                                  : '0;
    entry.channel  = channel;
    entry.in_range = (int'(channel) < NUM_CHANNELS);
    entry.above    = (radius > cfg.threshold);
    entry.below    = (radius < cfg.exit_level);
    entry.eof      = end_of_frame;
  end

  assign in_ready = (count != QCNT_W'(QDEPTH)) && !busy;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/mvd_back.sv -----
module mvd_back #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  mvd_pkg::entry_t q_entry,
  output logic            q_pop,
  input  mvd_pkg::cfg_t   cfg,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            channel_void,
  output logic            any_void,
  output logic            void_changed
);
  import mvd_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [NUM_CHANNELS-1:0] flags;
  logic [NUM_CHANNELS-1:0] flags_next;
  logic [DEB_W-1:0]        enter_cnt [NUM_CHANNELS];
  logic [DEB_W-1:0]        exit_cnt  [NUM_CHANNELS];
  logic                    global_flag;

  logic [IDX_W-1:0] idx;
  logic             flag;
  logic             propose;
  logic [DEB_W-1:0] e_cur;
  logic [DEB_W-1:0] x_cur;
  logic [DEB_W-1:0] e_inc;
  logic [DEB_W-1:0] x_inc;
  logic [DEB_W-1:0] e_new;
  logic [DEB_W-1:0] x_new;
  logic             f_new;
  logic             agg;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    idx     = IDX_W'(q_entry.channel);
    flag    = flags[idx];
    e_cur   = enter_cnt[idx];
    x_cur   = exit_cnt[idx];
    propose = flag ? !q_entry.below : q_entry.above;
    e_inc   = (e_cur == COUNT_MAX) ? e_cur : e_cur + 1'b1;
    x_inc   = (x_cur == COUNT_MAX) ? x_cur : x_cur + 1'b1;
    f_new   = flag;
    if (propose) begin
      e_new = e_inc;
      x_new = '0;
      if (!flag && e_inc >= cfg.deb_enter) begin
        f_new = 1'b1;
        e_new = '0;
      end
    end else begin
      e_new = '0;
      x_new = x_inc;
      if (flag && x_inc >= cfg.deb_exit) begin
        f_new = 1'b0;
        x_new = '0;
      end
    end
    flags_next = flags;
    if (q_entry.in_range) begin
      flags_next[idx] = f_new;
    end
    agg = |flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags       <= '0;
      global_flag <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        enter_cnt[i] <= '0;
        exit_cnt[i]  <= '0;
      end
    end else if (q_pop) begin
      flags <= flags_next;
      if (q_entry.in_range) begin
        enter_cnt[idx] <= e_new;
        exit_cnt[idx]  <= x_new;
      end
      if (q_entry.eof) begin
        global_flag <= agg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      channel_void <= q_entry.in_range && f_new;
      any_void     <= q_entry.eof ? agg : global_flag;
      void_changed <= q_entry.eof && (agg != global_flag);
    end
  end

endmodule

// ----- sv/multichannel_void_detector.sv -----
// Multichannel void detector with per-channel hysteresis and debounce.
// The input channel carries one distance measurement per transfer, tagged
// with its sensor channel and an end-of-frame mark. The output channel
// returns one result per input transfer, in order: the channel's debounced
// void flag, the global void flag and whether that flag changed at this
// frame end. Both channels use valid/ready handshakes.
// A transfer is classified against the thresholds on entry and placed in a
// two-entry queue; the back end updates the channel state and loads the
// output register. The queue registers each transfer, and the back end
// pops it into the registered output. One transfer per cycle is sustained
// while the receiver is ready and no configuration write is settling,
// limited by the single read-modify-write of channel state in the back end.
// When the receiver stalls, the output register holds its result and the
// queue absorbs up to two more transfers before in_ready drops.
// Configuration writes go through cfg_we, cfg_index and cfg_data. After
// each write, and after reset, in_ready stays low while the exit level
// pipeline settles. Reset clears all channel flags, counters, the global
// flag and the queue, and restores register defaults.
module multichannel_void_detector #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mvd_pkg::CHAN_W-1:0]     channel,
  input  logic                           target_valid,
  input  logic [mvd_pkg::DIST_W-1:0]     measured_distance_mm,
  input  logic                           end_of_frame,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           channel_void,
  output logic                           any_void,
  output logic                           void_changed,
  input  logic                           cfg_we,
  input  logic [mvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mvd_pkg::*;

  cfg_t   cfg;
  logic   busy;
  logic   q_valid;
  entry_t q_entry;
  logic   q_pop;

  mvd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .busy      (busy)
  );

  mvd_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .channel              (channel),
    .target_valid         (target_valid),
    .measured_distance_mm (measured_distance_mm),
    .end_of_frame         (end_of_frame),
    .cfg                  (cfg),
    .busy                 (busy),
    .q_valid              (q_valid),
    .q_entry              (q_entry),
    .q_pop                (q_pop)
  );

  mvd_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .cfg          (cfg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .channel_void (channel_void),
    .any_void     (any_void),
    .void_changed (void_changed)
  );

endmodule

// ----- sv/mvd_checker.sv -----
module mvd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic channel_void,
  input logic any_void,
  input logic void_changed,
  input logic cfg_we
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_reset_stalls_in: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("Input ready right after reset.");

  a_cfg_stalls_in: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("Input ready right after a configuration write.");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("Input valid dropped before its transfer.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel_void)
      && $stable(any_void) && $stable(void_changed))
    else $error("Stalled output transfer changed.");

endmodule

bind multichannel_void_detector mvd_checker u_mvd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .channel_void (channel_void),
  .any_void     (any_void),
  .void_changed (void_changed),
  .cfg_we       (cfg_we)
);
